>>> rtl/srcc_pkg.sv
package srcc_pkg;

   localparam int MAX_OBSTACLES = 64;
   localparam int COORD_BITS    = 20;

   localparam int IDX_BITS   = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
   localparam int COUNT_BITS = $clog2(MAX_OBSTACLES + 1);
   localparam int STORED_COUNT_BITS = 7;

   // Widths of the edge test arithmetic.
   localparam int DIFF_BITS = COORD_BITS + 1;
   localparam int PROD_BITS = 2 * DIFF_BITS;
   localparam int SUM_BITS  = PROD_BITS + 1;

   localparam logic OP_ADD   = 1'b0;
   localparam logic OP_CHECK = 1'b1;

   // Rectangle sides in test order.
   localparam logic [1:0] SIDE_LOW_Y  = 2'd0;
   localparam logic [1:0] SIDE_LOW_X  = 2'd1;
   localparam logic [1:0] SIDE_HIGH_X = 2'd2;
   localparam logic [1:0] SIDE_HIGH_Y = 2'd3;

   typedef struct packed {
      logic                         op;
      logic signed [COORD_BITS-1:0] point_a_x;
      logic signed [COORD_BITS-1:0] point_a_y;
      logic signed [COORD_BITS-1:0] point_b_x;
      logic signed [COORD_BITS-1:0] point_b_y;
   } req_type;

   typedef struct packed {
      logic                         hit;
      logic                         table_full;
      logic [STORED_COUNT_BITS-1:0] stored_count;
   } rsp_type;

   typedef struct packed {
      logic                load_req;
      logic                issue_valid;
      logic [IDX_BITS-1:0] issue_idx;
      logic [1:0]          issue_side;
      logic                load_rsp;
   } srcc_cmd_type;

   typedef struct packed {
      logic [COUNT_BITS-1:0] count;
      logic                  hit_seen;
   } srcc_stat_type;

   function automatic logic signed [DIFF_BITS-1:0] sub_c(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      sub_c = $signed({a[COORD_BITS-1], a}) - $signed({b[COORD_BITS-1], b});
   endfunction

   function automatic logic signed [COORD_BITS-1:0] min_c(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      min_c = (a < b) ? a : b;
   endfunction

   function automatic logic signed [COORD_BITS-1:0] max_c(
      input logic signed [COORD_BITS-1:0] a,
      input logic signed [COORD_BITS-1:0] b);
      max_c = (a > b) ? a : b;
   endfunction

endpackage

>>> rtl/srcc_ctrl.sv
module srcc_ctrl
   import srcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   input  logic          req_is_check,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  srcc_stat_type stat,
   output srcc_cmd_type  cmd
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_DRAIN  = 2'd2;
   localparam logic [1:0] ST_FINISH = 2'd3;

   // Drain counter start value: the last issued side test reaches the hit flag first.
   localparam logic [1:0] DRAIN_INIT = 2'd2;

   logic [1:0]          state_ff, state_in;
   logic [IDX_BITS-1:0] idx_ff, idx_in;
   logic [1:0]          side_ff, side_in;
   logic [1:0]          drain_ff, drain_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                last_obstacle;

   assign last_obstacle =
      (COUNT_BITS'({1'b0, idx_ff}) + COUNT_BITS'(1)) == stat.count;

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      side_in      = side_ff;
      drain_in     = drain_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      req_ready    = (state_ff == ST_IDLE);
      cmd          = '0;
      cmd.issue_idx  = idx_ff;
      cmd.issue_side = side_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               idx_in       = '0;
               side_in      = SIDE_LOW_Y;
               if (req_is_check && (stat.count != '0)) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end
         ST_SCAN: begin
            cmd.issue_valid = 1'b1;
            if (stat.hit_seen) begin
               drain_in = DRAIN_INIT;
               state_in = ST_DRAIN;
            end else if (side_ff == SIDE_HIGH_Y) begin
               side_in = SIDE_LOW_Y;
               if (last_obstacle) begin
                  drain_in = DRAIN_INIT;
                  state_in = ST_DRAIN;
               end else begin
                  idx_in = idx_ff + IDX_BITS'(1);
               end
            end else begin
               side_in = side_ff + 2'd1;
            end
         end
         ST_DRAIN: begin
            if (drain_ff == '0) begin
               state_in = ST_FINISH;
            end else begin
               drain_in = drain_ff - 2'd1;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         side_ff      <= SIDE_LOW_Y;
         drain_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         side_ff      <= side_in;
         drain_ff     <= drain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   // A scan only ever runs over a nonempty table.
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (stat.count != '0))
      else $error("scan started on an empty table");

   // A new response is only raised out of the finish state.
   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_FINISH))
      else $error("response raised outside finish");

   // An index never passes the stored count.
   a_idx_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (COUNT_BITS'({1'b0, idx_ff}) < stat.count))
      else $error("scan index beyond stored count");

endmodule

>>> rtl/srcc_datapath.sv
module srcc_datapath
   import srcc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  req_type       req_data,
   input  srcc_cmd_type  cmd,
   output srcc_stat_type stat,
   output rsp_type       rsp_data
);

   typedef struct packed {
      logic signed [COORD_BITS-1:0] x1;
      logic signed [COORD_BITS-1:0] y1;
      logic signed [COORD_BITS-1:0] x2;
      logic signed [COORD_BITS-1:0] y2;
   } rect_type;

   rect_type              rect_mem [MAX_OBSTACLES];
   rect_type              rd_ff;
   req_type               req_ff;
   rsp_type               rsp_ff;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic                  full;
   logic                  hit_ff;
   rect_type              wr_rect;

   logic       s1_vld_ff, s2_vld_ff, s3_vld_ff;
   logic [1:0] s1_side_ff;

   // Stage two: operands of one side test.
   logic signed [DIFF_BITS-1:0] k_ff, j_ff, v_ff, dl_ff, dh_ff;
   logic                        ok2_ff;
   // Stage three: products.
   logic signed [PROD_BITS-1:0] pl_ff, ph_ff, pj_ff;
   logic                        ok3_ff, kneg3_ff;
   // Final compare of stage three.
   logic signed [SUM_BITS-1:0]  dlow, dhigh;
   logic                        dl_pos, dl_neg, dh_pos, dh_neg, side_hit;

   assign full = (count_ff == COUNT_BITS'(MAX_OBSTACLES));

   always_comb begin
      wr_rect = '{x1: req_ff.point_a_x, y1: req_ff.point_a_y,
                  x2: req_ff.point_b_x, y2: req_ff.point_b_y};
      if ((req_ff.point_a_x > req_ff.point_b_x) &&
          (req_ff.point_a_y > req_ff.point_b_y)) begin
         wr_rect = '{x1: req_ff.point_b_x, y1: req_ff.point_b_y,
                     x2: req_ff.point_a_x, y2: req_ff.point_a_y};
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.load_rsp && (req_ff.op == OP_ADD) && !full) begin
         count_in = count_ff + COUNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff  <= '0;
         hit_ff    <= 1'b0;
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         s3_vld_ff <= 1'b0;
      end else begin
         count_ff  <= count_in;
         s1_vld_ff <= cmd.issue_valid;
         s2_vld_ff <= s1_vld_ff;
         s3_vld_ff <= s2_vld_ff;
         if (cmd.load_req) begin
            hit_ff <= 1'b0;
         end else if (s3_vld_ff && side_hit) begin
            hit_ff <= 1'b1;
         end
      end
   end

   // Obstacle memory: one write port for adds, one registered read for scans.
   always_ff @(posedge clock) begin
      if (cmd.load_rsp && (req_ff.op == OP_ADD) && !full) begin
         rect_mem[count_ff[IDX_BITS-1:0]] <= wr_rect;
      end
      rd_ff <= rect_mem[cmd.issue_idx];
   end

   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         req_ff <= req_data;
      end
      if (cmd.load_rsp) begin
         rsp_ff.hit          <= (req_ff.op == OP_CHECK) && hit_ff;
         rsp_ff.table_full   <= (req_ff.op == OP_ADD) && full;
         rsp_ff.stored_count <= STORED_COUNT_BITS'({{STORED_COUNT_BITS{1'b0}}, count_in});
      end
      s1_side_ff <= cmd.issue_side;
   end

   // Stage one: pick the side, reduce both ranges to one open interval.
   logic                         horiz;
   logic signed [COORD_BITS-1:0] fix_c, e0, e1, s0, s1, lo, hi;
   logic signed [DIFF_BITS-1:0]  a1, b1, k_c, j_c, v_c;

   always_comb begin
      a1 = sub_c(req_ff.point_b_y, req_ff.point_a_y);
      b1 = sub_c(req_ff.point_a_x, req_ff.point_b_x);
      horiz = 1'b1;
      fix_c = rd_ff.y1;
      e0    = rd_ff.x1;
      e1    = rd_ff.x2;
      unique case (s1_side_ff)
         SIDE_LOW_Y: begin
            horiz = 1'b1; fix_c = rd_ff.y1; e0 = rd_ff.x1; e1 = rd_ff.x2;
         end
         SIDE_LOW_X: begin
            horiz = 1'b0; fix_c = rd_ff.x1; e0 = rd_ff.y1; e1 = rd_ff.y2;
         end
         SIDE_HIGH_X: begin
            horiz = 1'b0; fix_c = rd_ff.x2; e0 = rd_ff.y2; e1 = rd_ff.y1;
         end
         SIDE_HIGH_Y: begin
            horiz = 1'b1; fix_c = rd_ff.y2; e0 = rd_ff.x2; e1 = rd_ff.x1;
         end
         default: begin
            horiz = 1'b1;
         end
      endcase
      if (horiz) begin
         k_c = a1;
         j_c = b1;
         s0  = req_ff.point_a_x;
         s1  = req_ff.point_b_x;
         v_c = sub_c(req_ff.point_a_y, fix_c);
      end else begin
         k_c = b1;
         j_c = a1;
         s0  = req_ff.point_a_y;
         s1  = req_ff.point_b_y;
         v_c = sub_c(req_ff.point_a_x, fix_c);
      end
      lo = max_c(min_c(e0, e1), min_c(s0, s1));
      hi = min_c(max_c(e0, e1), max_c(s0, s1));
   end

   always_ff @(posedge clock) begin
      k_ff   <= k_c;
      j_ff   <= j_c;
      v_ff   <= v_c;
      dl_ff  <= sub_c(s0, lo);
      dh_ff  <= sub_c(s0, hi);
      ok2_ff <= (k_c != '0) && (e0 != e1);
   end

   // Stage three: the three products of the crossing compare.
   always_ff @(posedge clock) begin
      pl_ff    <= PROD_BITS'(k_ff) * PROD_BITS'(dl_ff);
      ph_ff    <= PROD_BITS'(k_ff) * PROD_BITS'(dh_ff);
      pj_ff    <= PROD_BITS'(j_ff) * PROD_BITS'(v_ff);
      ok3_ff   <= ok2_ff;
      kneg3_ff <= k_ff[DIFF_BITS-1];
   end

   // Stage three: the crossing lies strictly above lo and below hi.
   always_comb begin
      dlow   = SUM_BITS'(pl_ff) + SUM_BITS'(pj_ff);
      dhigh  = SUM_BITS'(ph_ff) + SUM_BITS'(pj_ff);
      dl_neg = dlow[SUM_BITS-1];
      dl_pos = !dlow[SUM_BITS-1] && (dlow != '0);
      dh_neg = dhigh[SUM_BITS-1];
      dh_pos = !dhigh[SUM_BITS-1] && (dhigh != '0);
      side_hit = ok3_ff && (kneg3_ff ? (dl_neg && dh_pos) : (dl_pos && dh_neg));
   end

   assign stat.count    = count_ff;
   assign stat.hit_seen = hit_ff;
   assign rsp_data      = rsp_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= COUNT_BITS'(MAX_OBSTACLES))
      else $error("obstacle count beyond table depth");

   a_full_holds: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_rsp && full) |=> (count_ff == $past(count_ff)))
      else $error("count moved on a full table");

   a_count_only_on_rsp: assert property (@(posedge clock) disable iff (reset)
      !$past(cmd.load_rsp) |-> $stable(count_ff))
      else $error("count changed outside response load");

endmodule

>>> rtl/segment_rectangle_collision_check.sv
// An add request goes from acceptance straight to its response; a
// check request scans the stored rectangles until a side is hit, one
// rectangle side per cycle through a three-stage multiply pipeline.
// Requests are handled one at a time.
// Reset (synchronous, active high) empties the table by clearing its count;
// the rectangle memory itself is not cleared and needs no clearing pass.
module segment_rectangle_collision_check
   import srcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   // The controller sequences each request: an add goes straight to the
   // response stage, a check walks the stored rectangles side by side until a
   // side is hit. The datapath holds the request, the rectangle memory, the
   // side-test pipeline and the response register. A finished response waits in
   // its register until it is taken, and the next request is accepted meanwhile.

   srcc_cmd_type  cmd;
   srcc_stat_type stat;

   srcc_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_is_check (req_data.op == OP_CHECK),
      .req_ready    (req_ready),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .stat         (stat),
      .cmd          (cmd)
   );

   // A check stops issuing sides once a crossing side has reached the hit flag;
   // sides already in flight only drain through the pipeline.
   srcc_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .cmd      (cmd),
      .stat     (stat),
      .rsp_data (rsp_data)
   );

endmodule

>>> bench/srcc_checker.sv
module srcc_checker
   import srcc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count
);

   // Shadow copy of the obstacle table.
   logic signed [COORD_BITS-1:0] lo_x [MAX_OBSTACLES];
   logic signed [COORD_BITS-1:0] lo_y [MAX_OBSTACLES];
   logic signed [COORD_BITS-1:0] hi_x [MAX_OBSTACLES];
   logic signed [COORD_BITS-1:0] hi_y [MAX_OBSTACLES];
   int      held;
   rsp_type expected_rsp_q[$];

   assign pending_count = expected_rsp_q.size();

   // Appends one predicted response at the tail of the queue.
   function automatic void queue_expected(input rsp_type r);
      expected_rsp_q = {expected_rsp_q, r};
   endfunction

   // Sign of num/det - m, exact.
   function automatic int ratio_sign(input logic signed [127:0] num,
                                     input logic signed [127:0] det,
                                     input logic signed [127:0] m);
      logic signed [127:0] d;
      d = num - m * det;
      if (det < 0) d = -d;
      if (d == 0) return 0;
      return (d < 0) ? -1 : 1;
   endfunction

   function automatic bit inside_both(input logic signed [127:0] num,
                                      input logic signed [127:0] det,
                                      input logic signed [127:0] e0, e1, f0, f1);
      logic signed [127:0] elo, ehi, flo, fhi;
      elo = (e0 < e1) ? e0 : e1;
      ehi = (e0 > e1) ? e0 : e1;
      flo = (f0 < f1) ? f0 : f1;
      fhi = (f0 > f1) ? f0 : f1;
      return ratio_sign(num, det, elo) > 0 && ratio_sign(num, det, ehi) < 0 &&
             ratio_sign(num, det, flo) > 0 && ratio_sign(num, det, fhi) < 0;
   endfunction

   function automatic bit segment_crosses_edge(
      input logic signed [127:0] sx1, sy1, sx2, sy2, qx1, qy1, qx2, qy2);
      logic signed [127:0] a1, b1, c1, a2, b2, c2, det, xn, yn;
      a1 = sy2 - sy1;
      b1 = sx1 - sx2;
      c1 = a1 * sx1 + b1 * sy1;
      a2 = qy2 - qy1;
      b2 = qx1 - qx2;
      c2 = a2 * qx1 + b2 * qy1;
      det = a1 * b2 - a2 * b1;
      if (det == 0) return 1'b0;
      xn = b2 * c1 - b1 * c2;
      yn = a1 * c2 - a2 * c1;
      if (inside_both(xn, det, sx1, sx2, qx1, qx2)) return 1'b1;
      return inside_both(yn, det, sy1, sy2, qy1, qy2);
   endfunction

   function automatic rsp_type predict_response(input req_type r);
      rsp_type p;
      logic signed [127:0] ax, ay, bx, by, x1, y1, x2, y2;
      p = '0;
      ax = 128'(r.point_a_x);
      ay = 128'(r.point_a_y);
      bx = 128'(r.point_b_x);
      by = 128'(r.point_b_y);
      if (r.op == OP_ADD) begin
         if (held >= MAX_OBSTACLES) begin
            p.table_full = 1'b1;
         end else begin
            // Only a corner pair that is greater in both axes gets swapped.
            if (ax > bx && ay > by) begin
               lo_x[IDX_BITS'(held)] = r.point_b_x;
               lo_y[IDX_BITS'(held)] = r.point_b_y;
               hi_x[IDX_BITS'(held)] = r.point_a_x;
               hi_y[IDX_BITS'(held)] = r.point_a_y;
            end else begin
               lo_x[IDX_BITS'(held)] = r.point_a_x;
               lo_y[IDX_BITS'(held)] = r.point_a_y;
               hi_x[IDX_BITS'(held)] = r.point_b_x;
               hi_y[IDX_BITS'(held)] = r.point_b_y;
            end
            held++;
         end
      end else begin
         for (int i = 0; i < held; i++) begin
            x1 = 128'(lo_x[IDX_BITS'(i)]);
            y1 = 128'(lo_y[IDX_BITS'(i)]);
            x2 = 128'(hi_x[IDX_BITS'(i)]);
            y2 = 128'(hi_y[IDX_BITS'(i)]);
            if (segment_crosses_edge(ax, ay, bx, by, x1, y1, x2, y1) ||
                segment_crosses_edge(ax, ay, bx, by, x1, y1, x1, y2) ||
                segment_crosses_edge(ax, ay, bx, by, x2, y2, x2, y1) ||
                segment_crosses_edge(ax, ay, bx, by, x2, y2, x1, y2)) begin
               p.hit = 1'b1;
               break;
            end
         end
      end
      p.stored_count = held[STORED_COUNT_BITS-1:0];
      return p;
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         held = 0;
         fail_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               fail_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.hit !== want.hit || rsp_data.table_full !== want.table_full
                   || rsp_data.stored_count !== want.stored_count) begin
                  $display("%0t: mismatch expected %p actual %p", $time, want, rsp_data);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            queue_expected(predict_response(req_data));
      end
   end

endmodule

>>> bench/tb_top.sv
module tb_top
   import srcc_pkg::*;
();

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;
   int      fail_count;
   int      pending_count;

   // Percent chances of the sender idling and the receiver stalling.
   int      send_idle_pct = 0;
   int      stall_pct = 0;
   longint  cycle_count = 0;

   localparam longint CYCLE_LIMIT = 3_000_000;

   localparam int CMIN = -(2 ** (COORD_BITS - 1));
   localparam int CMAX = (2 ** (COORD_BITS - 1)) - 1;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   segment_rectangle_collision_check uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   srcc_checker checker_i (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   // The receiver decides its ready each cycle independently of the sender.
   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   // Watchdog: a hung block must not keep the run alive forever.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // Sends one request: optional idle cycles first, then hold valid until the
   // block accepts it. Valid is never dropped and raised in the same step,
   // because idle cycles only happen before valid goes up.
   task automatic send_request(input logic op, input int ax, input int ay,
                               input int bx, input int by);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= '{op: op,
                     point_a_x: COORD_BITS'(ax), point_a_y: COORD_BITS'(ay),
                     point_b_x: COORD_BITS'(bx), point_b_y: COORD_BITS'(by)};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic go_idle();
      req_valid <= 1'b0;
   endtask

   function automatic int random_coord();
      case ($urandom_range(9))
         0: return CMIN;
         1: return CMAX;
         2, 3, 4, 5: return int'($urandom_range(4096)) - 2048;
         default: return int'($signed(COORD_BITS'($urandom)));
      endcase
   endfunction

   // Mostly a segment aimed through the middle of a small area, so hits are common.
   task automatic send_random_check();
      int cx, cy;
      if ($urandom_range(3) == 0) begin
         send_request(OP_CHECK, random_coord(), random_coord(), random_coord(),
                      random_coord());
      end else begin
         cx = int'($urandom_range(2000)) - 1000;
         cy = int'($urandom_range(2000)) - 1000;
         send_request(OP_CHECK, cx - 1500, cy + int'($urandom_range(600)),
                      cx + 1500, cy - int'($urandom_range(600)));
      end
   endtask

   task automatic send_random_add();
      int x0, y0;
      if ($urandom_range(4) == 0) begin
         send_request(OP_ADD, random_coord(), random_coord(), random_coord(),
                      random_coord());
      end else begin
         x0 = int'($urandom_range(3000)) - 1500;
         y0 = int'($urandom_range(3000)) - 1500;
         // Either corner order, so the swap path gets exercised too.
         if ($urandom_range(1))
            send_request(OP_ADD, x0, y0, x0 + int'($urandom_range(1, 400)),
                         y0 + int'($urandom_range(1, 400)));
         else
            send_request(OP_ADD, x0 + int'($urandom_range(1, 400)),
                         y0 + int'($urandom_range(1, 400)), x0, y0);
      end
   endtask

   task automatic wait_drained();
      go_idle();
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Reset empties the table, but the phases do not reset it: the first reset is
   // the only one, so later phases just fill on from where they are.
   task automatic random_phase(input int n_items, input int idle_pct, input int stl_pct);
      send_idle_pct = idle_pct;
      stall_pct = stl_pct;
      for (int i = 0; i < n_items; i++) begin
         if ($urandom_range(99) < 20)
            send_random_add();
         else
            send_random_check();
      end
      wait_drained();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: empty-table check, swapped and plain corners, degenerate
      // segments, parallel lines and extreme coordinates.
      send_request(OP_CHECK, -100, 0, 100, 0);
      send_request(OP_ADD, 100, 100, -100, -100);
      send_request(OP_CHECK, -200, 0, 200, 0);
      send_request(OP_CHECK, -200, 100, 200, 100);
      send_request(OP_CHECK, 5, 5, 5, 5);
      send_request(OP_CHECK, 0, -300, 0, 300);
      send_request(OP_CHECK, -50, -50, 50, 50);
      send_request(OP_ADD, -500, 500, 500, -500);
      send_request(OP_ADD, 300, 300, 300, 400);
      send_request(OP_CHECK, 250, 350, 350, 350);
      send_request(OP_ADD, CMIN, CMIN, CMAX, CMAX);
      send_request(OP_CHECK, CMIN, CMAX, CMAX, CMIN);
      send_request(OP_CHECK, CMAX, CMAX, CMIN, CMIN);
      send_request(OP_CHECK, CMIN, 0, CMAX, 0);
      send_request(OP_CHECK, 1000, 1000, 1000, 2000);
      // The sender waits for everything to come back before going on.
      wait_drained();

      random_phase(450, 0, 0);
      random_phase(450, 59, 0);
      random_phase(450, 0, 59);
      random_phase(320, 27, 27);

      // Overfill the table; the extra adds must be flagged as dropped.
      for (int i = 0; i < 70; i++) send_random_add();
      send_random_check();
      wait_drained();

      repeat (300) @(posedge clock);
      if (fail_count == 0 && pending_count == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule

>>> segment_rectangle_collision_check.f
rtl/srcc_pkg.sv
rtl/srcc_ctrl.sv
rtl/srcc_datapath.sv
rtl/segment_rectangle_collision_check.sv
bench/srcc_checker.sv
bench/tb_top.sv
